FILE: hw/rtl/u2a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and the digit-to-ASCII mapping for the
// unsigned-to-ASCII radix converter.
// ----------------------------------------------------------------------------
package u2a_pkg;

	// conversion kinds
	typedef enum logic [1:0] {
		KIND_DEC       = 2'd0,
		KIND_HEX_LOWER = 2'd1,
		KIND_HEX_UPPER = 2'd2,
		KIND_PTR       = 2'd3
	} kind_t;

	localparam int unsigned ValueWidth = 64;
	localparam int unsigned CharWidth  = 8;
	localparam int unsigned DigitWidth = 4;
	// enough digit slots for a 64-bit value in hex
	localparam int unsigned DigitSlots = 16;
	localparam int unsigned SlotIdxWidth = $clog2(DigitSlots);

	// reciprocal of ten: floor(v * DecRecip / 2**DecShift) == v / 10 for any 32-bit v
	localparam logic [31:0] DecRecip = 32'hCCCC_CCCD;
	localparam int unsigned DecShift = 35;
	localparam logic [3:0]  DecRadix = 4'd10;

	localparam logic [CharWidth-1:0] ChZero  = 8'h30;
	localparam logic [CharWidth-1:0] ChX     = 8'h78;
	localparam logic [CharWidth-1:0] ChLowA  = 8'h61;
	localparam logic [CharWidth-1:0] ChHighA = 8'h41;

	// ASCII code of one digit, letters in the chosen case
	function automatic logic [CharWidth-1:0] digit_char(input logic [DigitWidth-1:0] d,
			input logic upper);
		logic [CharWidth-1:0] base;
		base = upper ? ChHighA : ChLowA;
		if (d < DecRadix) begin
			digit_char = ChZero + {4'd0, d};
		end else begin
			digit_char = base + {4'd0, d - DecRadix};
		end
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/unsigned_to_ascii_radix_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix_core
// Converts one unsigned value to ASCII text (decimal, hex or 0x-prefixed
// 64-bit hex), one character per output transaction, most significant first.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload          | direction
//  --------+--------------------+------------------+----------
//  input   | in_valid/in_stall  | kind, value      | in
//  output  | out_valid/out_stall| character, last  | out
//
// One input transaction is loaded, then the digits are taken off one by one in
// the shared divide unit (a multiply by the reciprocal of ten, or a 4-bit
// shift), then the characters go out one per output transaction, most significant first.
// in_stall is high from load until the last character has entered the
// output register. Output stalls hold the prefix and emit states; reset clears control.
//
module unsigned_to_ascii_radix_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     kind,
	input  wire logic [u2a_pkg::ValueWidth-1:0] value,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [u2a_pkg::CharWidth-1:0]       character,
	output logic                                last
);
	import u2a_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_PFX0,
		ST_PFXX,
		ST_EMIT
	} state_t;

	state_t                   state_q;
	kind_t                    kind_q;
	logic [ValueWidth-1:0]    val_q;
	logic [DigitWidth-1:0]    digit_q [DigitSlots];
	logic [SlotIdxWidth-1:0]  cnt_q;
	logic [SlotIdxWidth-1:0]  idx_q;
	logic                     out_valid_q;
	logic [CharWidth-1:0]     char_q;
	logic                     last_q;

	logic [63:0]              prod;
	logic [ValueWidth-1:0]    quot;
	logic [DigitWidth-1:0]    rem;
	logic [31:0]              dec_q;
	logic [31:0]              dec_times10;
	logic [31:0]              dec_rem;
	logic                     out_free;
	logic                     out_load;
	logic                     in_accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	// a character enters the output register this cycle
	assign out_load  = out_free && ((state_q == ST_PFX0) || (state_q == ST_PFXX) ||
	                                (state_q == ST_EMIT));

	// shared divide unit: one digit off the bottom per cycle
	always_comb begin
		prod        = {32'd0, val_q[31:0]} * {32'd0, DecRecip};
		dec_q       = {3'd0, prod[63:DecShift]};
		dec_times10 = (dec_q << 3) + (dec_q << 1);
		dec_rem     = val_q[31:0] - dec_times10;
		if (kind_q == KIND_DEC) begin
			quot = {32'd0, dec_q};
			rem  = dec_rem[DigitWidth-1:0];
		end else begin
			quot = val_q >> DigitWidth;
			rem  = val_q[DigitWidth-1:0];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			kind_q      <= KIND_DEC;
			val_q       <= '0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= out_load;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						kind_q  <= kind_t'(kind);
						val_q   <= (kind_t'(kind) == KIND_PTR) ? value
						           : {32'd0, value[31:0]};
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					digit_q[cnt_q] <= rem;
					cnt_q          <= cnt_q + 1'b1;
					val_q          <= quot;
					if (quot == '0) begin
						idx_q   <= cnt_q;
						state_q <= (kind_q == KIND_PTR) ? ST_PFX0 : ST_EMIT;
					end
				end
				ST_PFX0: begin
					if (out_free) begin
						char_q  <= ChZero;
						last_q  <= 1'b0;
						state_q <= ST_PFXX;
					end
				end
				ST_PFXX: begin
					if (out_free) begin
						char_q  <= ChX;
						last_q  <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						char_q <= digit_char(digit_q[idx_q], kind_q == KIND_HEX_UPPER);
						last_q <= (idx_q == '0);
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: tb/sv/tb_unsigned_to_ascii_radix_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unsigned_to_ascii_radix_core
// Self-checking bench for the unsigned-to-ASCII converter. Numbers are sent
// with random gaps, the expected text of each one is worked out here, and
// every character transaction on the output side is compared in order,
// under random output stalls.
// ----------------------------------------------------------------------------
module tb_unsigned_to_ascii_radix_core;
	import u2a_pkg::*;

	// one expected character of the text
	typedef struct packed {
		logic [CharWidth-1:0] code;
		logic                 last;
	} text_char_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            kind;
	logic [ValueWidth-1:0] value;
	logic                  out_valid;
	logic                  out_stall;
	logic [CharWidth-1:0]  character;
	logic                  last;

	text_char_t expected_text[$];
	int         error_count;
	int         numbers_sent;
	int         chars_checked;
	int         kind_count[4];
	int         stall_left;
	bit         no_idle;

	unsigned_to_ascii_radix_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	// clock, 4 ns period
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// wait cycles before a transaction, zero during a no-idle stretch
	function automatic int draw_wait();
		if (no_idle) begin
			return 0;
		end
		return $urandom_range(0, 10);
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("mismatch: %s", msg);
	endtask

	// ascii digit for one nibble, letters in the chosen case
	function automatic logic [CharWidth-1:0] nibble_ascii(input logic [3:0] d,
			input logic upper);
		if (d < 4'd10) begin
			return 8'h30 + {4'd0, d};
		end
		return (upper ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
	endfunction

	// expected text of one number, appended to the queue
	task automatic predict_text(input logic [1:0] k, input logic [ValueWidth-1:0] v);
		logic [CharWidth-1:0] rev[20];
		logic [31:0]          dec_rem;
		logic [63:0]          hex_rem;
		int                   ndig;
		text_char_t           item;
		ndig = 0;
		if (k == KIND_DEC) begin
			dec_rem = v[31:0];
			do begin
				rev[ndig] = 8'h30 + 8'(dec_rem % 32'd10);
				ndig++;
				dec_rem = dec_rem / 32'd10;
			end while (dec_rem != 32'd0);
		end else begin
			hex_rem = (k == KIND_PTR) ? v : {32'd0, v[31:0]};
			do begin
				rev[ndig] = nibble_ascii(hex_rem[3:0], k == KIND_HEX_UPPER);
				ndig++;
				hex_rem = hex_rem >> 4;
			end while (hex_rem != 64'd0);
		end
		if (k == KIND_PTR) begin
			item.code = 8'h30;
			item.last = 1'b0;
			expected_text.push_back(item);
			item.code = 8'h78;
			expected_text.push_back(item);
		end
		for (int i = ndig - 1; i >= 0; i--) begin
			item.code = rev[i];
			item.last = (i == 0);
			expected_text.push_back(item);
		end
	endtask

	// send one number; valid stays high afterwards unless the next one waits
	task automatic send_number(input logic [1:0] k, input logic [ValueWidth-1:0] v);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		value    <= v;
		do @(posedge clk); while (!(in_valid && !in_stall));
		predict_text(k, v);
		numbers_sent++;
		kind_count[k]++;
	endtask

	// output side: random stalls and in-order check of every character
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				chars_checked++;
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("unexpected character 0x%02h last %0b",
						character, last));
				end else begin
					if (character !== expected_text[0].code) begin
						report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
							character, expected_text[0].code));
					end
					if (last !== expected_text[0].last) begin
						report_mismatch($sformatf("last %0b, expected %0b on 0x%02h",
							last, expected_text[0].last, expected_text[0].code));
					end
					void'(expected_text.pop_front());
				end
				stall_left = draw_wait();
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	// zero in every kind, also with upper bits set for the 32-bit kinds
	task automatic test_zero_values();
		send_number(KIND_DEC, 64'd0);
		send_number(KIND_HEX_LOWER, 64'd0);
		send_number(KIND_HEX_UPPER, 64'd0);
		send_number(KIND_PTR, 64'd0);
		send_number(KIND_DEC, 64'hFFFF_FFFF_0000_0000);
		send_number(KIND_HEX_UPPER, 64'h0000_0001_0000_0000);
	endtask

	// longest and shortest texts, digit rollovers, letters in both cases
	task automatic test_extreme_values();
		send_number(KIND_DEC, 64'h0000_0000_FFFF_FFFF);
		send_number(KIND_HEX_LOWER, 64'h0000_0000_FFFF_FFFF);
		send_number(KIND_HEX_UPPER, 64'h0000_0000_FFFF_FFFF);
		send_number(KIND_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
		send_number(KIND_PTR, 64'h8000_0000_0000_0000);
		send_number(KIND_DEC, 64'd9);
		send_number(KIND_DEC, 64'd10);
		send_number(KIND_DEC, 64'd1_000_000_000);
		send_number(KIND_HEX_LOWER, 64'h0000_0000_ABCD_EF09);
		send_number(KIND_HEX_UPPER, 64'h0000_0000_FEDC_BA98);
		send_number(KIND_HEX_LOWER, 64'd15);
		send_number(KIND_HEX_UPPER, 64'd16);
		send_number(KIND_PTR, 64'd1);
		send_number(KIND_PTR, 64'h0123_4567_89AB_CDEF);
	endtask

	// upper half is dropped for the 32-bit kinds
	task automatic test_ignored_upper_bits();
		send_number(KIND_DEC, 64'hDEAD_BEEF_0000_007B);
		send_number(KIND_HEX_LOWER, 64'hFFFF_FFFF_0000_0A0B);
		send_number(KIND_HEX_UPPER, 64'h5555_AAAA_8000_0000);
	endtask

	// random kinds, values of random significant width, idle and busy stretches
	task automatic test_random_numbers(input int count);
		logic [ValueWidth-1:0] v;
		int                    bits;
		for (int n = 0; n < count; n++) begin
			if (n % 30 == 0) begin
				no_idle = ($urandom_range(0, 2) == 0);
			end
			v = {$urandom, $urandom};
			bits = $urandom_range(0, 64);
			if (bits < 64 && $urandom_range(0, 3) != 0) begin
				v = v & ((64'd1 << bits) - 64'd1);
			end
			send_number(2'($urandom_range(0, 3)), v);
		end
		no_idle = 1'b0;
	endtask

	// limit on the whole run
	initial begin
		#2_000_000;
		$display("timeout with %0d characters still expected", expected_text.size());
		$display("TB_ERROR");
		$finish;
	end

	// reset, tests, drain and final verdict
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		kind          = KIND_DEC;
		value         = '0;
		out_stall     = 1'b0;
		error_count   = 0;
		numbers_sent  = 0;
		chars_checked = 0;
		stall_left    = 0;
		no_idle       = 1'b0;
		foreach (kind_count[i]) kind_count[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_values();
		test_extreme_values();
		test_ignored_upper_bits();
		test_random_numbers(97);

		in_valid <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("sent %0d numbers (dec %0d, hex lower %0d, hex upper %0d, 0x %0d)",
			numbers_sent, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
		$display("checked %0d characters, %0d mismatches", chars_checked, error_count);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/u2a_pkg.sv
hw/rtl/unsigned_to_ascii_radix_core.sv
tb/sv/tb_unsigned_to_ascii_radix_core.sv
